// ===== src/btb_pkg.sv =====
// Shared types and constants for the branch target buffer next-PC predictor.
// No dependencies; imported by the queue, the core and the top level.
`default_nettype none
package btb_pkg;

    localparam int BTB_ENTRIES = 16;
    localparam int PC_W        = 32;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 40;

    localparam logic [1:0] OUTCOME_NOT_TAKEN = 2'd0;
    localparam logic [1:0] OUTCOME_TAKEN     = 2'd1;
    localparam logic [1:0] OUTCOME_NOT_SET   = 2'd3;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [PC_W-1:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic            op;
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] target;
        logic            taken;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef enum logic {
        S_MATCH,
        S_APPLY
    } t_state;

endpackage
`default_nettype wire

// ===== src/btb_queue.sv =====
// Front end: accepts request beats, unpacks them and holds them in a two-entry queue.
// Depends on btb_pkg for the item types.
`default_nettype none
module btb_queue (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pc [31:0], target [63:32], taken [64], zero fill [71:65]
    input  wire logic [btb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op [0]
    input  wire logic                            s_axis_tuser,
    input  wire logic                            i_pop,
    output btb_pkg::t_q_head                     o_head
);
    import btb_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_in_item;
    logic       w_push;

    always_comb begin
        w_in_item.op     = s_axis_tuser;
        w_in_item.pc     = s_axis_tdata[31:0];
        w_in_item.target = s_axis_tdata[63:32];
        w_in_item.taken  = s_axis_tdata[64];
    end

    assign s_axis_tready = (r_count != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_in_item;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire

// ===== src/btb_core.sv =====
// Back end: tag match, LRU rank upkeep, entry writes and the result register.
// Depends on btb_pkg for the item types, outcome codes and state enum.
`default_nettype none
module btb_core #(
    parameter int ENTRIES = btb_pkg::BTB_ENTRIES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire btb_pkg::t_q_head                i_head,
    output logic                                 o_pop,
    output logic [ENTRIES-1:0]                   o_sel_vec,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // next_pc [31:0], hit [32], zero fill [39:33]
    output logic [btb_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
    import btb_pkg::*;

    localparam int AGE_W = $clog2(ENTRIES);
    localparam logic [AGE_W-1:0] OLDEST = AGE_W'(ENTRIES - 1);

    t_state r_state;
    t_state n_state;

    // Entry file: valid bits and ranks are reset, payload is not.
    logic [ENTRIES-1:0] r_valid;
    logic [AGE_W-1:0]   r_age    [ENTRIES];
    logic [PC_W-1:0]    r_tag    [ENTRIES];
    logic [PC_W-1:0]    r_target [ENTRIES];
    logic [1:0]         r_outcome[ENTRIES];

    // Match results captured for the apply cycle.
    logic               r_op;
    logic [PC_W-1:0]    r_pc;
    logic [PC_W-1:0]    r_new_target;
    logic               r_taken;
    logic               r_hit;
    logic [ENTRIES-1:0] r_sel_vec;
    logic [AGE_W-1:0]   r_sel_age;
    logic [PC_W-1:0]    r_sel_target;
    logic [1:0]         r_sel_outcome;

    logic                 r_out_valid;
    logic [PC_W-1:0]      r_out_next_pc;
    logic                 r_out_hit;

    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_free;
    logic [ENTRIES-1:0] w_free_first;
    logic [ENTRIES-1:0] w_lru;
    logic [ENTRIES-1:0] w_ins;
    logic [ENTRIES-1:0] w_sel;
    logic               w_hit;
    logic [AGE_W-1:0]   w_sel_age;
    logic [PC_W-1:0]    w_sel_target;
    logic [1:0]         w_sel_outcome;
    logic               w_out_free;
    logic               w_commit;
    logic [PC_W-1:0]    w_next_pc;

    // Comparators against every entry; the buffer is fully associative.
    always_comb begin
        w_sel_age     = '0;
        w_sel_target  = '0;
        w_sel_outcome = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == i_head.item.pc);
            w_lru[i]   = r_age[i] == OLDEST;
            if (w_match[i]) begin
                w_sel_age     = w_sel_age | r_age[i];
                w_sel_target  = w_sel_target | r_target[i];
                w_sel_outcome = w_sel_outcome | r_outcome[i];
            end
        end
    end

    // When the file is full the ranks are a permutation, so exactly one entry
    // holds the oldest rank and it is the victim.
    assign w_hit        = |w_match;
    assign w_free       = ~r_valid;
    assign w_free_first = w_free & (~w_free + ENTRIES'(1));
    assign w_ins        = (&r_valid) ? w_lru : w_free_first;
    assign w_sel        = w_hit ? w_match
                        : ((i_head.item.op == OP_LOOKUP) ? w_ins : '0);

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_MATCH: begin
                if (i_head.valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_MATCH;
                end
            end
            default: n_state = S_MATCH;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        w_commit = 1'b0;
        case (r_state)
            S_MATCH: o_pop    = i_head.valid;
            S_APPLY: w_commit = w_out_free;
            default: begin
                o_pop    = 1'b0;
                w_commit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_MATCH;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_vec <= '0;
        end else if (o_pop) begin
            r_sel_vec <= w_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op          <= i_head.item.op;
            r_pc          <= i_head.item.pc;
            r_new_target  <= i_head.item.target;
            r_taken       <= i_head.item.taken;
            r_hit         <= w_hit;
            r_sel_age     <= w_sel_age;
            r_sel_target  <= w_sel_target;
            r_sel_outcome <= w_sel_outcome;
        end
    end

    // A hit ages only the entries younger than the touched one; an insert
    // ages every other valid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else if (w_commit && (r_op == OP_LOOKUP)) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_sel_vec[i]) begin
                    r_valid[i] <= 1'b1;
                    r_age[i]   <= '0;
                end else if (r_valid[i] && (!r_hit || (r_age[i] < r_sel_age))) begin
                    r_age[i] <= r_age[i] + AGE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_sel_vec[i]) begin
                    if (r_op == OP_UPDATE) begin
                        r_outcome[i] <= r_taken ? OUTCOME_TAKEN : OUTCOME_NOT_TAKEN;
                    end else if (!r_hit) begin
                        r_tag[i]     <= r_pc;
                        r_target[i]  <= r_new_target;
                        r_outcome[i] <= OUTCOME_NOT_SET;
                    end
                end
            end
        end
    end

    always_comb begin
        if (r_op == OP_UPDATE) begin
            w_next_pc = '0;
        end else if (r_hit && (r_sel_outcome == OUTCOME_TAKEN)) begin
            w_next_pc = r_sel_target;
        end else begin
            w_next_pc = r_pc + PC_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_next_pc <= w_next_pc;
            r_out_hit     <= r_hit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_hit, r_out_next_pc};
    assign o_sel_vec     = r_sel_vec;

endmodule
`default_nettype wire

// ===== src/btb_lru_next_pc_predictor.sv =====
// Fully associative branch target buffer with LRU replacement. A lookup beat
// (tuser = 0) returns the stored target when the PC hits and its last outcome
// was taken, otherwise PC+4, and on a miss inserts the PC into a free entry or
// over the least recent one. An update beat (tuser = 1) records the taken bit
// of an entry that is present; next_pc is zero and hit tells whether it was
// found. Every request yields exactly one result beat. Each request passes
// through the back end's match state, which compares the PC against all tags
// and picks the entry, and then its apply state, which writes the entry file
// and the result register; the core pops no new request until that is done.
// A stalled result register holds the apply state until it drains, while a
// two-entry queue keeps taking requests. Reset clears the valid bits at once;
// no clearing pass is needed. Depends on btb_pkg, btb_queue and btb_core.
`default_nettype none
module btb_lru_next_pc_predictor #(
    parameter int ENTRIES = btb_pkg::BTB_ENTRIES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pc [31:0], target [63:32], taken [64], zero fill [71:65]
    input  wire logic [btb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op [0]
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // next_pc [31:0], hit [32], zero fill [39:33]
    output logic [btb_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
    import btb_pkg::*;

    t_q_head            w_head;
    logic               w_pop;
    logic [ENTRIES-1:0] w_sel_vec;

    btb_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (w_pop),
        .o_head        (w_head)
    );

    btb_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_sel_vec     (w_sel_vec),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // The core only takes a request that the queue actually holds.
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("core popped an empty queue");

    // Each request occupies the core for its match state and its apply state.
    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !w_pop)
        else $error("core popped in consecutive cycles");

    // At most one entry is chosen for a hit, an insert or an update.
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel_vec))
        else $error("more than one entry selected");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for btb_lru_next_pc_predictor: a directed warm-up, then
// random lookup/update streams over PC pools of varying size, with random idling.
// Depends on btb_pkg and the RTL of the predictor.
`timescale 1ns / 100ps

module tb;
    import btb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            hit;
    } t_result;

    // Tracks the buffer contents and LRU ranks, and holds the results still owed.
    class next_pc_scoreboard;
        bit              slot_valid   [BTB_ENTRIES];
        logic [PC_W-1:0] slot_tag     [BTB_ENTRIES];
        logic [PC_W-1:0] slot_target  [BTB_ENTRIES];
        logic [1:0]      slot_outcome [BTB_ENTRIES];
        int              slot_age     [BTB_ENTRIES];
        int              used_slots;
        t_result         owed_results [$];
        int              mismatches;

        function new();
            foreach (slot_valid[i]) begin
                slot_valid[i] = 1'b0;
                slot_age[i]   = 0;
            end
            used_slots = 0;
            mismatches = 0;
        endfunction

        function int locate_pc(logic [PC_W-1:0] pc);
            for (int i = 0; i < BTB_ENTRIES; i++) begin
                if (slot_valid[i] && slot_tag[i] == pc)
                    return i;
            end
            return -1;
        endfunction

        // Entries more recent than the old rank age by one; the slot becomes newest.
        function void promote(int s, int old_rank);
            for (int i = 0; i < BTB_ENTRIES; i++) begin
                if (i != s && slot_valid[i] && slot_age[i] < old_rank)
                    slot_age[i]++;
            end
            slot_age[s] = 0;
        endfunction

        function t_result predict_next_pc(logic op, logic [PC_W-1:0] pc,
                                          logic [PC_W-1:0] target, logic taken);
            t_result res;
            int      s;
            int      victim;
            int      rank;
            res.next_pc = '0;
            res.hit     = 1'b0;
            s = locate_pc(pc);
            if (op == OP_UPDATE) begin
                if (s >= 0) begin
                    slot_outcome[s] = taken ? OUTCOME_TAKEN : OUTCOME_NOT_TAKEN;
                    res.hit = 1'b1;
                end
            end else if (s >= 0) begin
                res.hit     = 1'b1;
                res.next_pc = (slot_outcome[s] == OUTCOME_TAKEN) ? slot_target[s] : pc + PC_STEP;
                promote(s, slot_age[s]);
            end else begin
                victim = -1;
                if (used_slots < BTB_ENTRIES) begin
                    for (int i = 0; i < BTB_ENTRIES && victim < 0; i++) begin
                        if (!slot_valid[i])
                            victim = i;
                    end
                end
                if (victim >= 0) begin
                    used_slots++;
                    rank = BTB_ENTRIES;
                end else begin
                    // Buffer is full: the oldest entry gives way.
                    rank   = 0;
                    victim = 0;
                    for (int i = 0; i < BTB_ENTRIES; i++) begin
                        if (slot_valid[i] && slot_age[i] >= rank) begin
                            rank   = slot_age[i];
                            victim = i;
                        end
                    end
                end
                slot_valid[victim]   = 1'b1;
                slot_tag[victim]     = pc;
                slot_target[victim]  = target;
                slot_outcome[victim] = OUTCOME_NOT_SET;
                promote(victim, rank);
                res.next_pc = pc + PC_STEP;
            end
            return res;
        endfunction

        function void note_request(logic op, logic [PC_W-1:0] pc,
                                   logic [PC_W-1:0] target, logic taken);
            owed_results.push_back(predict_next_pc(op, pc, target, taken));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            t_result got;
            t_result want;
            got.next_pc = beat[PC_W-1:0];
            got.hit     = beat[PC_W];
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with none outstanding: next_pc=%h hit=%b",
                             $realtime, got.next_pc, got.hit);
            end else begin
                want = owed_results.pop_front();
                if (got.next_pc !== want.next_pc || got.hit !== want.hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch: next_pc exp %h got %h, hit exp %b got %b",
                                 $realtime, want.next_pc, got.next_pc, want.hit, got.hit);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // pc [31:0], target [63:32], taken [64], zero fill [71:65]
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // op [0]
    logic                 s_axis_tuser = OP_LOOKUP;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // next_pc [31:0], hit [32], zero fill [39:33]
    logic [M_TDATA_W-1:0] m_axis_tdata;

    next_pc_scoreboard board = new();
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int stall_left = 0;
    int cycles = 0;

    btb_lru_next_pc_predictor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            stall_left = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic op, input logic [PC_W-1:0] pc,
                                input logic [PC_W-1:0] target, input logic taken);
        int gap;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-2*PC_W-1){1'b0}}, taken, target, pc};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(op, pc, target, taken);
    endtask

    // Mostly PCs from a small pool so lookups hit, updates find their entry and
    // pools larger than the buffer force evictions; a few fully random PCs.
    task automatic run_pool_phase(input int count, input int pool_size);
        logic [PC_W-1:0] pool [$];
        logic [PC_W-1:0] pc;
        logic            op;
        repeat (pool_size) pool.push_back($urandom);
        repeat (count) begin
            if ($urandom_range(0, 99) < 8)
                pc = $urandom;
            else
                pc = pool[$urandom_range(0, pool_size - 1)];
            op = ($urandom_range(0, 99) < 35) ? OP_UPDATE : OP_LOOKUP;
            send_request(op, pc, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 20;
        sink_idle_pct = 20;
        // Update on an empty buffer, insert, hit before any outcome, taken and
        // not-taken outcomes, PC+4 wrapping at the top of the address space.
        send_request(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678, 1'b0);
        send_request(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_request(OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h5555_5555, 1'b1);
        send_request(OP_LOOKUP, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b1);
        // Fill the buffer and evict the oldest entries, then miss on the first.
        for (int i = 0; i < 16; i++)
            send_request(OP_LOOKUP, 32'h0000_1000 + 4 * i, $urandom, 1'b0);
        send_request(OP_LOOKUP, 32'h0000_0000, 32'h0BAD_F00D, 1'b0);

        src_idle_pct = 0;  sink_idle_pct = 0;  run_pool_phase(50, 6);
        src_idle_pct = 30; sink_idle_pct = 30; run_pool_phase(50, 12);
        src_idle_pct = 10; sink_idle_pct = 40; run_pool_phase(60, 18);
        src_idle_pct = 40; sink_idle_pct = 10; run_pool_phase(60, 24);
        src_idle_pct = 20; sink_idle_pct = 20; run_pool_phase(60, 40);
        src_idle_pct = 50; sink_idle_pct = 50; run_pool_phase(40, 16);
        src_idle_pct = 0;  sink_idle_pct = 0;  run_pool_phase(80, 20);
        s_axis_tvalid <= 1'b0;

        while (board.owed_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.owed_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
